>>> hw/rtl/sector_disk_controller_core_assert.svh
// Assertion macros used by the checker file of the sector disk controller.
`ifndef SECTOR_DISK_CONTROLLER_CORE_ASSERT_SVH
`define SECTOR_DISK_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sector disk controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sector disk controller check failed");

`endif

>>> hw/rtl/sdc_pkg.sv
`default_nettype none

package sdc_pkg;

   // Bus window geometry.
   localparam int ADDR_BITS    = 20;
   localparam int BUF_WORDS    = 512;
   localparam int BUF_IDX_BITS = $clog2(BUF_WORDS);
   localparam int DATA_W       = 64;
   localparam int CAP_W        = 32;
   localparam int COUNTDOWN_W  = CAP_W + 1;
   localparam int XCOUNT_W     = 4;
   localparam int COUNT_BITS   = 3;

   localparam logic [ADDR_BITS-1:0] BUF_OFFSET = ADDR_BITS'(524288);
   localparam logic [ADDR_BITS:0]   BUF_BYTES  = (ADDR_BITS + 1)'(BUF_WORDS * 8);

   // Register offsets inside the window.
   localparam logic [ADDR_BITS-1:0] REG_CONTROL  = ADDR_BITS'(0);
   localparam logic [ADDR_BITS-1:0] REG_COUNT    = ADDR_BITS'(8);
   localparam logic [ADDR_BITS-1:0] REG_SECTOR   = ADDR_BITS'(16);
   localparam logic [ADDR_BITS-1:0] REG_CAPACITY = ADDR_BITS'(24);

   // Beat kinds carried in req_tuser.
   localparam int REQ_USER_W = 2;
   localparam logic [REQ_USER_W-1:0] OP_READ  = 2'd0;
   localparam logic [REQ_USER_W-1:0] OP_WRITE = 2'd1;
   localparam logic [REQ_USER_W-1:0] OP_TICK  = 2'd2;

   // Request data layout: address, then write data.
   localparam int REQ_ADDR_LSB  = 0;
   localparam int REQ_WDATA_LSB = ADDR_BITS;
   localparam int REQ_DATA_W    = ((ADDR_BITS + DATA_W + 7) / 8) * 8;

   // Response data layout, lowest field first.
   localparam int RSP_READ_LSB   = 0;
   localparam int RSP_FAULT_BIT  = DATA_W;
   localparam int RSP_IRQ_BIT    = DATA_W + 1;
   localparam int RSP_XV_BIT     = DATA_W + 2;
   localparam int RSP_XW_BIT     = DATA_W + 3;
   localparam int RSP_XS_LSB     = DATA_W + 4;
   localparam int RSP_XC_LSB     = RSP_XS_LSB + DATA_W;
   localparam int RSP_DATA_W     = RSP_XC_LSB + XCOUNT_W;

   // Control register bits.
   localparam int CB_W         = 6;
   localparam int CB_START_BIT = 0;
   localparam int CB_IEN_BIT   = 1;
   localparam int CB_WRITE_BIT = 2;
   localparam int CB_ERROR_BIT = 3;
   localparam int CB_DONE_BIT  = 4;
   localparam int CB_READY_BIT = 5;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPAN    = 2'd3;

   localparam logic [CAP_W-1:0] TOTAL_RESET   = 32'd0;
   localparam logic [CAP_W-1:0] STARTUP_RESET = 32'd1000;
   localparam logic [CAP_W-1:0] BASE_RESET    = 32'd100;
   localparam logic [CAP_W-1:0] SPAN_RESET    = 32'd1000;

   // What an expiring countdown stands for.
   localparam logic PEND_STARTUP = 1'b0;
   localparam logic PEND_COMMAND = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic mul;
      logic div_start;
      logic load_count;
      logic load_out;
      logic clear_step;
   } sdc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic exec_seek;
      logic div_done;
   } sdc_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/sector_disk_controller_core.sv
// Sector disk controller core.
// The request channel carries one bus read, bus write or timer tick per
// beat: the kind in req_tuser, the window offset and write data in
// req_tdata. Every request beat gives exactly one response beat, in order,
// with read data, fault, interrupt level and any transfer request that a
// completing command raises. Configuration registers are written through
// csr_we, csr_index and csr_wdata; the user must write them only while no
// request is in work; the block does not enforce this. A read, write or
// tick goes from the capture registers via the result registers to the
// response register. A write of the start bit with a disk present also
// computes the seek time with one multiply and a one bit per cycle divider.
// One request is in work at a time; the next is accepted while an earlier
// response still waits in the response register. After reset the sector
// buffer is cleared one word a cycle, with no request accepted until done.
// When the receiver stalls, the response stays in its register, the
// following request still executes, and its response waits for the slot.
`default_nettype none

module sector_disk_controller_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request beat.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // req_tdata fields from bit 0: address, write_data, zero padding.
   input  wire logic [sdc_pkg::REQ_DATA_W-1:0]       req_tdata,
   // req_tuser fields from bit 0: opcode.
   input  wire logic [sdc_pkg::REQ_USER_W-1:0]       req_tuser,
   // Response beat.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // rsp_tdata fields from bit 0: read_data, fault, irq, xfer_valid,
   // xfer_write, xfer_sector, xfer_count.
   output logic      [sdc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // Configuration write port.
   input  wire logic                                 csr_we,
   input  wire logic [sdc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [sdc_pkg::CAP_W-1:0]            csr_wdata
);

   sdc_pkg::sdc_cmd_type    cmd;
   sdc_pkg::sdc_status_type status;

   sdc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd(cmd),
      .status(status)
   );

   sdc_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_tdata(rsp_tdata)
   );

endmodule

`default_nettype wire

>>> hw/rtl/sdc_ram.sv
`default_nettype none

// Generic simple dual-port RAM with a registered read port.
module sdc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // At most one write and one registered read in every cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sdc_divider.sv
`default_nettype none

// Restoring divider, one quotient bit a cycle. The caller guarantees that
// the upper half of the dividend is below the divisor, so the quotient
// fits in the lower half.
module sdc_divider (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [2*sdc_pkg::CAP_W-1:0]          dividend,
   input  wire logic [sdc_pkg::CAP_W-1:0]            divisor,
   output logic                                      done,
   output logic      [sdc_pkg::CAP_W-1:0]            quotient
);

   localparam int QW  = sdc_pkg::CAP_W;
   localparam int CNW = $clog2(QW + 1);

   logic [QW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]  quo_ff, quo_in;
   logic [CNW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [QW:0]    trial;
   logic [QW:0]    diff;
   logic           ge;

   // Trial subtraction of one step.
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         rem_in = dividend[2*QW-1:QW];
         quo_in = dividend[QW-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? diff[QW-1:0] : trial[QW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
      end
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sdc_datapath.sv
`default_nettype none

// Datapath of the disk controller: device registers, configuration, the
// sector buffer, the seek time multiplier and divider, and the response
// registers.
module sdc_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sdc_pkg::sdc_cmd_type                 cmd,
   output sdc_pkg::sdc_status_type                   status,
   input  wire logic [sdc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire logic [sdc_pkg::REQ_USER_W-1:0]       req_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [sdc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [sdc_pkg::CAP_W-1:0]            csr_wdata,
   output logic      [sdc_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int AB = sdc_pkg::ADDR_BITS;
   localparam int DW = sdc_pkg::DATA_W;
   localparam int CW = sdc_pkg::CAP_W;
   localparam int IB = sdc_pkg::BUF_IDX_BITS;
   localparam int TW = sdc_pkg::COUNTDOWN_W;
   localparam int XW = sdc_pkg::XCOUNT_W;
   localparam int NB = sdc_pkg::COUNT_BITS;

   // Captured beat.
   logic [sdc_pkg::REQ_USER_W-1:0] op_ff;
   logic [AB-1:0]                  off_ff;
   logic [DW-1:0]                  wd_ff;

   // Device state.
   logic [sdc_pkg::CB_W-1:0] cb_ff, cb_in;
   logic [DW-1:0]            count_ff, count_in;
   logic [DW-1:0]            sector_ff, sector_in;
   logic [CW-1:0]            cap_ff, cap_in;
   logic [DW-1:0]            prev_ff, prev_in;
   logic [TW-1:0]            cd_ff, cd_in;
   logic                     active_ff, active_in;
   logic                     pending_ff, pending_in;
   logic                     irq_ff, irq_in;

   // Configuration.
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] startup_ff, startup_in;
   logic [CW-1:0] base_ff, base_in;
   logic [CW-1:0] span_ff, span_in;

   // Seek arithmetic.
   logic [CW-1:0]   delta_ff;
   logic [2*CW-1:0] prod_ff;
   logic [CW-1:0]   quotient;
   logic            div_done;

   // Clearing pass.
   logic [IB-1:0] clr_ff, clr_in;

   // Result of the beat in work, and the response register.
   logic [DW-1:0] res_read_ff, res_read_in;
   logic          res_fault_ff, res_fault_in;
   logic          res_irq_ff;
   logic          res_xv_ff, res_xv_in;
   logic          res_xw_ff, res_xw_in;
   logic [DW-1:0] res_xs_ff, res_xs_in;
   logic [XW-1:0] res_xc_ff, res_xc_in;

   logic [DW-1:0] out_read_ff;
   logic          out_fault_ff;
   logic          out_irq_ff;
   logic          out_xv_ff;
   logic          out_xw_ff;
   logic [DW-1:0] out_xs_ff;
   logic [XW-1:0] out_xc_ff;

   // Buffer port signals.
   logic          buf_we;
   logic [IB-1:0] buf_waddr;
   logic [DW-1:0] buf_wdata;
   logic [IB-1:0] buf_raddr;
   logic [DW-1:0] buf_rdata;

   logic [AB-1:0] req_rel;
   logic [AB-1:0] item_rel;
   logic          item_in_buf;
   logic          seek;
   logic [DW-1:0] diff;
   logic [CW-1:0] delta_clip;
   logic [NB-1:0] num_m1;
   logic [XW-1:0] num;
   logic          xfer_ok;

   // The buffer read is issued straight from the incoming beat.
   assign req_rel   = req_tdata[sdc_pkg::REQ_ADDR_LSB +: AB] - sdc_pkg::BUF_OFFSET;
   assign buf_raddr = req_rel[IB+2:3];

   assign item_rel    = off_ff - sdc_pkg::BUF_OFFSET;
   assign item_in_buf = (off_ff >= sdc_pkg::BUF_OFFSET) &&
                        ({1'b0, item_rel} < sdc_pkg::BUF_BYTES);

   // Seek distance, clipped to the capacity.
   assign diff       = (sector_ff >= prev_ff) ? (sector_ff - prev_ff) : (prev_ff - sector_ff);
   assign delta_clip = (diff > {{(DW-CW){1'b0}}, cap_ff}) ? cap_ff : diff[CW-1:0];

   // Sectors moved by a command: the count modulo eight, zero meaning eight.
   assign num_m1  = count_ff[NB-1:0] - 1'b1;
   assign num     = {1'b0, num_m1} + 1'b1;
   assign xfer_ok = (cap_ff != '0) &&
                    (sector_ff < {{(DW-CW){1'b0}}, cap_ff}) &&
                    (({1'b0, sector_ff} + (DW + 1)'(num)) <= {{(DW-CW+1){1'b0}}, cap_ff});

   sdc_ram #(
      .WIDTH(DW),
      .DEPTH(sdc_pkg::BUF_WORDS)
   ) u_buf (
      .clock(clock),
      .we(buf_we),
      .waddr(buf_waddr),
      .wdata(buf_wdata),
      .raddr(buf_raddr),
      .rdata(buf_rdata)
   );

   sdc_divider u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .dividend(prod_ff),
      .divisor(cap_ff),
      .done(div_done),
      .quotient(quotient)
   );

   // Buffer clearing, execution of one beat, countdown reload and configuration writes.
   always_comb begin
      cb_in      = cb_ff;
      count_in   = count_ff;
      sector_in  = sector_ff;
      cap_in     = cap_ff;
      prev_in    = prev_ff;
      cd_in      = cd_ff;
      active_in  = active_ff;
      pending_in = pending_ff;
      irq_in     = irq_ff;
      total_in   = total_ff;
      startup_in = startup_ff;
      base_in    = base_ff;
      span_in    = span_ff;
      clr_in     = clr_ff;
      buf_we     = 1'b0;
      buf_waddr  = clr_ff;
      buf_wdata  = '0;
      seek       = 1'b0;
      res_read_in  = '0;
      res_fault_in = 1'b0;
      res_xv_in    = 1'b0;
      res_xw_in    = 1'b0;
      res_xs_in    = '0;
      res_xc_in    = '0;

      if (cmd.clear_step) begin
         buf_we = 1'b1;
         clr_in = clr_ff + 1'b1;
      end

      if (cmd.exec) begin
         unique case (op_ff)
            sdc_pkg::OP_READ: begin
               priority if (off_ff == sdc_pkg::REG_CONTROL) begin
                  res_read_in = DW'(cb_ff);
               end else if (off_ff == sdc_pkg::REG_COUNT) begin
                  res_read_in = count_ff;
               end else if (off_ff == sdc_pkg::REG_SECTOR) begin
                  res_read_in = sector_ff;
               end else if (off_ff == sdc_pkg::REG_CAPACITY) begin
                  res_read_in = DW'(cap_ff);
               end else if (item_in_buf) begin
                  res_read_in = buf_rdata;
               end else begin
                  res_fault_in = 1'b1;
               end
            end
            sdc_pkg::OP_WRITE: begin
               priority if (off_ff == sdc_pkg::REG_CONTROL) begin
                  cb_in[sdc_pkg::CB_IEN_BIT]   = wd_ff[sdc_pkg::CB_IEN_BIT];
                  cb_in[sdc_pkg::CB_WRITE_BIT] = wd_ff[sdc_pkg::CB_WRITE_BIT];
                  if (wd_ff[sdc_pkg::CB_START_BIT]) begin
                     cb_in[sdc_pkg::CB_START_BIT] = 1'b1;
                     cb_in[sdc_pkg::CB_ERROR_BIT] = 1'b0;
                     cb_in[sdc_pkg::CB_DONE_BIT]  = 1'b0;
                     seek = (cap_ff != '0);
                  end else begin
                     cb_in[sdc_pkg::CB_START_BIT] = 1'b0;
                     cb_in[sdc_pkg::CB_ERROR_BIT] = wd_ff[sdc_pkg::CB_ERROR_BIT];
                     cb_in[sdc_pkg::CB_DONE_BIT]  = wd_ff[sdc_pkg::CB_DONE_BIT];
                  end
                  irq_in = cb_in[sdc_pkg::CB_IEN_BIT] & cb_in[sdc_pkg::CB_DONE_BIT];
               end else if (off_ff == sdc_pkg::REG_COUNT) begin
                  count_in = wd_ff;
               end else if (off_ff == sdc_pkg::REG_SECTOR) begin
                  sector_in = wd_ff;
               end else if (off_ff == sdc_pkg::REG_CAPACITY) begin
                  res_fault_in = 1'b1;
               end else if (item_in_buf) begin
                  buf_we    = 1'b1;
                  buf_waddr = item_rel[IB+2:3];
                  buf_wdata = wd_ff;
               end else begin
                  res_fault_in = 1'b1;
               end
            end
            sdc_pkg::OP_TICK: begin
               if (active_ff) begin
                  if (cd_ff > TW'(1)) begin
                     cd_in = cd_ff - 1'b1;
                  end else begin
                     active_in = 1'b0;
                     if (pending_ff == sdc_pkg::PEND_STARTUP) begin
                        cap_in = total_ff;
                        cb_in[sdc_pkg::CB_READY_BIT] = 1'b1;
                     end else begin
                        if (xfer_ok) begin
                           res_xv_in = 1'b1;
                           res_xw_in = cb_ff[sdc_pkg::CB_WRITE_BIT];
                           res_xs_in = sector_ff;
                           res_xc_in = num;
                           prev_in   = sector_ff + DW'(num_m1);
                        end else begin
                           cb_in[sdc_pkg::CB_ERROR_BIT] = 1'b1;
                        end
                        cb_in[sdc_pkg::CB_START_BIT] = 1'b0;
                        cb_in[sdc_pkg::CB_DONE_BIT]  = 1'b1;
                        if (cb_ff[sdc_pkg::CB_IEN_BIT]) begin
                           irq_in = 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // A started command arms its countdown once the seek time is known.
      if (cmd.load_count) begin
         cd_in      = {1'b0, base_ff} + {1'b0, quotient};
         active_in  = 1'b1;
         pending_in = sdc_pkg::PEND_COMMAND;
      end

      // Configuration writes; before ready, total or startup writes restart startup.
      if (csr_we) begin
         unique case (csr_index)
            sdc_pkg::CSR_TOTAL:   total_in   = csr_wdata;
            sdc_pkg::CSR_STARTUP: startup_in = csr_wdata;
            sdc_pkg::CSR_BASE:    base_in    = csr_wdata;
            sdc_pkg::CSR_SPAN:    span_in    = csr_wdata;
         endcase
         if (((csr_index == sdc_pkg::CSR_TOTAL) || (csr_index == sdc_pkg::CSR_STARTUP)) &&
             !cb_ff[sdc_pkg::CB_READY_BIT]) begin
            cd_in      = {1'b0, startup_in};
            active_in  = (total_in != '0);
            pending_in = sdc_pkg::PEND_STARTUP;
         end
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff      <= '0;
         count_ff   <= '0;
         sector_ff  <= '0;
         cap_ff     <= '0;
         prev_ff    <= '0;
         cd_ff      <= {1'b0, sdc_pkg::STARTUP_RESET};
         active_ff  <= (sdc_pkg::TOTAL_RESET != '0);
         pending_ff <= sdc_pkg::PEND_STARTUP;
         irq_ff     <= 1'b0;
         total_ff   <= sdc_pkg::TOTAL_RESET;
         startup_ff <= sdc_pkg::STARTUP_RESET;
         base_ff    <= sdc_pkg::BASE_RESET;
         span_ff    <= sdc_pkg::SPAN_RESET;
         clr_ff     <= '0;
      end else begin
         cb_ff      <= cb_in;
         count_ff   <= count_in;
         sector_ff  <= sector_in;
         cap_ff     <= cap_in;
         prev_ff    <= prev_in;
         cd_ff      <= cd_in;
         active_ff  <= active_in;
         pending_ff <= pending_in;
         irq_ff     <= irq_in;
         total_ff   <= total_in;
         startup_ff <= startup_in;
         base_ff    <= base_in;
         span_ff    <= span_in;
         clr_ff     <= clr_in;
      end
   end

   // Payload registers: captured beat, seek operands, result and response.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser;
         off_ff <= req_tdata[sdc_pkg::REQ_ADDR_LSB +: AB];
         wd_ff  <= req_tdata[sdc_pkg::REQ_WDATA_LSB +: DW];
      end
      if (cmd.exec) begin
         delta_ff     <= delta_clip;
         res_read_ff  <= res_read_in;
         res_fault_ff <= res_fault_in;
         res_irq_ff   <= irq_in;
         res_xv_ff    <= res_xv_in;
         res_xw_ff    <= res_xw_in;
         res_xs_ff    <= res_xs_in;
         res_xc_ff    <= res_xc_in;
      end
      if (cmd.mul) begin
         prod_ff <= delta_ff * span_ff;
      end
      if (cmd.load_out) begin
         out_read_ff  <= res_read_ff;
         out_fault_ff <= res_fault_ff;
         out_irq_ff   <= res_irq_ff;
         out_xv_ff    <= res_xv_ff;
         out_xw_ff    <= res_xw_ff;
         out_xs_ff    <= res_xs_ff;
         out_xc_ff    <= res_xc_ff;
      end
   end

   assign status.clear_last = (clr_ff == IB'(sdc_pkg::BUF_WORDS - 1));
   assign status.exec_seek  = seek;
   assign status.div_done   = div_done;

   assign rsp_tdata = {out_xc_ff, out_xs_ff, out_xw_ff, out_xv_ff,
                       out_irq_ff, out_fault_ff, out_read_ff};

endmodule

`default_nettype wire

>>> hw/rtl/sdc_ctrl.sv
`default_nettype none

// Sequencer of the disk controller: clears the buffer after reset, then
// takes one request beat at a time through execution, the optional seek
// computation and the response register.
module sdc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output sdc_pkg::sdc_cmd_type         cmd,
   input  wire sdc_pkg::sdc_status_type status
);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_EXEC      = 3'd2;
   localparam logic [2:0] S_MUL       = 3'd3;
   localparam logic [2:0] S_DIV_START = 3'd4;
   localparam logic [2:0] S_DIV_WAIT  = 3'd5;
   localparam logic [2:0] S_OUT       = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;

   // Next state, commands and response valid.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.exec_seek ? S_MUL : S_OUT;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.load_count = 1'b1;
               state_in       = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sdc_checker.sv
`default_nettype none

`include "sector_disk_controller_core_assert.svh"

// Checks on the response channel of the disk controller core.
module sdc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [sdc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [sdc_pkg::XCOUNT_W-1:0] xcount;
   logic                         xvalid;
   logic                         fault;

   assign xcount = rsp_tdata[sdc_pkg::RSP_XC_LSB +: sdc_pkg::XCOUNT_W];
   assign xvalid = rsp_tdata[sdc_pkg::RSP_XV_BIT];
   assign fault  = rsp_tdata[sdc_pkg::RSP_FAULT_BIT];

   // A stalled response beat holds.
   `SDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A transfer request moves one to eight sectors and never comes with a fault.
   `SDC_ASSERT_SAME(a_xfer_shape, clock, reset, rsp_tvalid && xvalid, (xcount != '0) && (xcount <= sdc_pkg::XCOUNT_W'(8)) && !fault)

   // Without a transfer request the transfer fields are all zero.
   `SDC_ASSERT_SAME(a_xfer_idle, clock, reset, rsp_tvalid && !xvalid, (xcount == '0) && !rsp_tdata[sdc_pkg::RSP_XW_BIT] && (rsp_tdata[sdc_pkg::RSP_XS_LSB +: sdc_pkg::DATA_W] == '0))

   // A faulting access returns no data and no transfer request.
   `SDC_ASSERT_SAME(a_fault_quiet, clock, reset, rsp_tvalid && fault, (rsp_tdata[sdc_pkg::RSP_READ_LSB +: sdc_pkg::DATA_W] == '0) && !xvalid)

endmodule

bind sector_disk_controller_core sdc_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
   import sdc_pkg::*;

   localparam int TIMEOUT_UNITS = 2_000_000;
   // Longest run of the block after its last response: a start with the divider.
   localparam int SETTLE_CYCLES = 48;
   localparam int SHOW_LIMIT    = 10;

   localparam logic [REQ_USER_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [DATA_W-1:0] CTRL_START = DATA_W'(1) << CB_START_BIT;
   localparam logic [DATA_W-1:0] CTRL_IEN   = DATA_W'(1) << CB_IEN_BIT;
   localparam logic [DATA_W-1:0] CTRL_WRITE = DATA_W'(1) << CB_WRITE_BIT;
   localparam logic [DATA_W-1:0] CTRL_ALL   = DATA_W'((1 << CB_W) - 1);
   localparam logic [DATA_W-1:0] COUNT_MASK = DATA_W'((1 << COUNT_BITS) - 1);

   localparam logic [ADDR_BITS-1:0] BUF_LAST_BYTE = BUF_OFFSET + ADDR_BITS'(BUF_WORDS * 8 - 1);
   localparam logic [ADDR_BITS-1:0] BUF_LAST_WORD = BUF_OFFSET + ADDR_BITS'(BUF_WORDS * 8 - 8);
   localparam logic [ADDR_BITS-1:0] BUF_PAST_END  = BUF_OFFSET + ADDR_BITS'(BUF_WORDS * 8);

   // One response beat, split into its fields.
   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic                fault;
      logic                irq;
      logic                xfer_valid;
      logic                xfer_write;
      logic [DATA_W-1:0]   xfer_sector;
      logic [XCOUNT_W-1:0] xfer_count;
   } disk_response_t;

   // Mirror of the controller state; it predicts one response per request beat.
   class sector_disk_mirror;
      bit [CAP_W-1:0]       total_sectors;
      bit [CAP_W-1:0]       startup_ticks;
      bit [CAP_W-1:0]       base_ticks;
      bit [CAP_W-1:0]       span_ticks;
      bit [CB_W-1:0]        control;
      bit [DATA_W-1:0]      count_word;
      bit [DATA_W-1:0]      sector_word;
      bit [DATA_W-1:0]      capacity;
      bit [DATA_W-1:0]      last_sector;
      bit [COUNTDOWN_W-1:0] countdown;
      bit                   countdown_active;
      bit                   pending_kind;
      bit                   irq_level;
      bit [DATA_W-1:0]      buffer_words [BUF_WORDS];
      disk_response_t       due_responses [$];
      int                   mismatches;

      function new();
         total_sectors = TOTAL_RESET;
         startup_ticks = STARTUP_RESET;
         base_ticks    = BASE_RESET;
         span_ticks    = SPAN_RESET;
         control       = '0;
         count_word    = '0;
         sector_word   = '0;
         capacity      = '0;
         last_sector   = '0;
         irq_level     = 1'b0;
         mismatches    = 0;
         foreach (buffer_words[i]) buffer_words[i] = '0;
         rearm_startup();
      endfunction

      function void rearm_startup();
         countdown        = COUNTDOWN_W'(startup_ticks);
         countdown_active = (total_sectors != 0);
         pending_kind     = PEND_STARTUP;
      endfunction

      // Disk size or startup wait written while not ready restarts the power-up wait.
      function void write_csr(logic [CSR_INDEX_W-1:0] index, logic [CAP_W-1:0] value);
         case (index)
            CSR_TOTAL:   total_sectors = value;
            CSR_STARTUP: startup_ticks = value;
            CSR_BASE:    base_ticks    = value;
            default:     span_ticks    = value;
         endcase
         if ((index == CSR_TOTAL || index == CSR_STARTUP) && !control[CB_READY_BIT]) begin
            rearm_startup();
         end
      endfunction

      function bit buffer_index(bit [ADDR_BITS-1:0] offset, output int unsigned idx);
         int unsigned rel;
         idx = 0;
         if (offset < BUF_OFFSET) return 1'b0;
         rel = offset - BUF_OFFSET;
         if (rel >= BUF_WORDS * 8) return 1'b0;
         idx = rel >> 3;
         return 1'b1;
      endfunction

      // A start arms the seek countdown if a disk is present; without start, error and done follow the data.
      function void write_control(bit [DATA_W-1:0] data);
         bit [DATA_W-1:0] delta;
         bit [DATA_W-1:0] quotient;
         control[CB_WRITE_BIT] = data[CB_WRITE_BIT];
         control[CB_IEN_BIT]   = data[CB_IEN_BIT];
         if (data[CB_START_BIT]) begin
            control[CB_START_BIT] = 1'b1;
            control[CB_ERROR_BIT] = 1'b0;
            control[CB_DONE_BIT]  = 1'b0;
            if (capacity != 0) begin
               delta = (sector_word >= last_sector) ? sector_word - last_sector
                                                    : last_sector - sector_word;
               if (delta > capacity) delta = capacity;
               quotient         = (delta * DATA_W'(span_ticks)) / capacity;
               countdown        = COUNTDOWN_W'(DATA_W'(base_ticks) + quotient);
               countdown_active = 1'b1;
               pending_kind     = PEND_COMMAND;
            end
         end else begin
            control[CB_START_BIT] = 1'b0;
            control[CB_ERROR_BIT] = data[CB_ERROR_BIT];
            control[CB_DONE_BIT]  = data[CB_DONE_BIT];
         end
         irq_level = control[CB_IEN_BIT] & control[CB_DONE_BIT];
      endfunction

      // Countdown expiry: either the disk comes ready or a command completes.
      function void expire(inout disk_response_t rsp);
         bit [DATA_W-1:0] moved;
         countdown_active = 1'b0;
         if (pending_kind == PEND_STARTUP) begin
            capacity              = DATA_W'(total_sectors);
            control[CB_READY_BIT] = 1'b1;
            return;
         end
         moved = ((count_word - 1) & COUNT_MASK) + 1;
         if (capacity != 0 && sector_word < capacity && sector_word + moved <= capacity) begin
            rsp.xfer_valid  = 1'b1;
            rsp.xfer_write  = control[CB_WRITE_BIT];
            rsp.xfer_sector = sector_word;
            rsp.xfer_count  = XCOUNT_W'(moved);
            last_sector     = sector_word + moved - 1;
         end else begin
            control[CB_ERROR_BIT] = 1'b1;
         end
         control[CB_START_BIT] = 1'b0;
         control[CB_DONE_BIT]  = 1'b1;
         if (control[CB_IEN_BIT]) irq_level = 1'b1;
      endfunction

      function void note_request(bit [REQ_USER_W-1:0] op, bit [ADDR_BITS-1:0] offset,
                                 bit [DATA_W-1:0] data);
         disk_response_t rsp;
         int unsigned    idx;
         rsp = '0;
         case (op)
            OP_READ: begin
               if (offset == REG_CONTROL)            rsp.read_data = DATA_W'(control);
               else if (offset == REG_COUNT)         rsp.read_data = count_word;
               else if (offset == REG_SECTOR)        rsp.read_data = sector_word;
               else if (offset == REG_CAPACITY)      rsp.read_data = capacity;
               else if (buffer_index(offset, idx))   rsp.read_data = buffer_words[idx];
               else                                  rsp.fault = 1'b1;
            end
            OP_WRITE: begin
               if (offset == REG_CONTROL)            write_control(data);
               else if (offset == REG_COUNT)         count_word = data;
               else if (offset == REG_SECTOR)        sector_word = data;
               else if (offset == REG_CAPACITY)      rsp.fault = 1'b1;
               else if (buffer_index(offset, idx))   buffer_words[idx] = data;
               else                                  rsp.fault = 1'b1;
            end
            OP_TICK: begin
               if (countdown_active) begin
                  if (countdown > 1) countdown = countdown - 1;
                  else expire(rsp);
               end
            end
            default: ;
         endcase
         rsp.irq = irq_level;
         due_responses.push_back(rsp);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] beat);
         disk_response_t got;
         disk_response_t want;
         got.read_data   = beat[RSP_READ_LSB +: DATA_W];
         got.fault       = beat[RSP_FAULT_BIT];
         got.irq         = beat[RSP_IRQ_BIT];
         got.xfer_valid  = beat[RSP_XV_BIT];
         got.xfer_write  = beat[RSP_XW_BIT];
         got.xfer_sector = beat[RSP_XS_LSB +: DATA_W];
         got.xfer_count  = beat[RSP_XC_LSB +: XCOUNT_W];
         if (due_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
               $display("unexpected response beat: %h", beat);
            end
            return;
         end
         want = due_responses.pop_front();
         if (got.read_data !== want.read_data || got.fault !== want.fault ||
             got.irq !== want.irq || got.xfer_valid !== want.xfer_valid ||
             got.xfer_write !== want.xfer_write || got.xfer_sector !== want.xfer_sector ||
             got.xfer_count !== want.xfer_count) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
               $display("response mismatch: expected rd=%h fault=%b irq=%b xv=%b xw=%b xs=%h xc=%0d",
                        want.read_data, want.fault, want.irq, want.xfer_valid,
                        want.xfer_write, want.xfer_sector, want.xfer_count);
               $display("                   actual   rd=%h fault=%b irq=%b xv=%b xw=%b xs=%h xc=%0d",
                        got.read_data, got.fault, got.irq, got.xfer_valid,
                        got.xfer_write, got.xfer_sector, got.xfer_count);
            end
         end
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [REQ_USER_W-1:0]   req_tuser  = OP_READ;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index  = CSR_TOTAL;
   logic [CAP_W-1:0]        csr_wdata  = '0;

   sector_disk_mirror mirror;
   int send_idle    = 0;
   int recv_idle    = 0;
   int hold_left    = 0;
   int items_sent   = 0;

   sector_disk_controller_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Receiver: a long hold-off when asked, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left  = hold_left - 1;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle);
      end
   end

   // Every accepted response beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         mirror.check_response(rsp_tdata);
      end
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("[sector_disk_controller_core] ERROR");
      $finish;
   end

   // Offer one request beat and wait until it is accepted.
   task automatic push_beat(input logic [REQ_USER_W-1:0] op, input logic [ADDR_BITS-1:0] offset,
                            input logic [DATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = op;
      req_tdata = '0;
      req_tdata[REQ_ADDR_LSB +: ADDR_BITS] = offset;
      req_tdata[REQ_WDATA_LSB +: DATA_W]   = data;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      mirror.note_request(op, offset, data);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Stop offering, wait for every response, then let the block run dry.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (mirror.due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      mirror.write_csr(index, value);
   endtask

   function automatic logic [ADDR_BITS-1:0] reg_offset(int unsigned pick);
      case (pick)
         0:       return REG_CONTROL;
         1:       return REG_COUNT;
         2:       return REG_SECTOR;
         default: return REG_CAPACITY;
      endcase
   endfunction

   function automatic logic [ADDR_BITS-1:0] pick_offset();
      case ($urandom_range(5))
         0, 1:    return reg_offset($urandom_range(3));
         2:       return BUF_OFFSET + ADDR_BITS'($urandom_range(BUF_WORDS * 8 - 1));
         3:       return ADDR_BITS'($urandom);
         4:       return ADDR_BITS'($urandom_range(31));
         default: return BUF_OFFSET + ADDR_BITS'($urandom_range(BUF_WORDS - 1) * 8);
      endcase
   endfunction

   // Sectors near the ends of the disk and near the head make the range and seek cases.
   function automatic logic [DATA_W-1:0] pick_sector();
      logic [DATA_W-1:0] cap;
      cap = mirror.capacity;
      case ($urandom_range(5))
         0:       return {$urandom, $urandom};
         1:       return DATA_W'($urandom_range(15));
         2:       return mirror.last_sector + DATA_W'($urandom_range(2));
         3:       return cap - DATA_W'($urandom_range(9));
         default: return DATA_W'($urandom_range(cap[CAP_W-1:0]));
      endcase
   endfunction

   // A well-formed command: set up, start, tick it through and read the status.
   task automatic run_command();
      int guard;
      if ($urandom_range(3) != 0) push_beat(OP_WRITE, REG_SECTOR, pick_sector());
      if ($urandom_range(2) != 0) push_beat(OP_WRITE, REG_COUNT, {$urandom, $urandom});
      push_beat(OP_WRITE, REG_CONTROL, {$urandom, $urandom} | CTRL_START);
      guard = 0;
      while (mirror.countdown_active && guard < 48) begin
         case ($urandom_range(11))
            0: push_beat(OP_READ, reg_offset($urandom_range(3)), {$urandom, $urandom});
            1: push_beat(OP_READ, pick_offset(), {$urandom, $urandom});
            2: push_beat(OP_WRITE, BUF_OFFSET + ADDR_BITS'($urandom_range(BUF_WORDS * 8 - 1)),
                         {$urandom, $urandom});
            3: begin
               // Occasionally restart while the countdown runs.
               if ($urandom_range(3) == 0) begin
                  push_beat(OP_WRITE, REG_CONTROL, {$urandom, $urandom} | CTRL_START);
               end else begin
                  push_beat(OP_TICK, ADDR_BITS'($urandom), {$urandom, $urandom});
               end
            end
            default: push_beat(OP_TICK, ADDR_BITS'($urandom), {$urandom, $urandom});
         endcase
         guard++;
      end
      push_beat(OP_READ, REG_CONTROL, {$urandom, $urandom});
      if ($urandom_range(2) == 0) begin
         push_beat(OP_WRITE, REG_CONTROL, {$urandom, $urandom} & ~CTRL_START);
      end
   endtask

   task automatic run_noise();
      logic [REQ_USER_W-1:0] op;
      op = REQ_USER_W'($urandom_range(3));
      if (op == OP_UNUSED && $urandom_range(3) != 0) op = OP_TICK;
      push_beat(op, pick_offset(), {$urandom, $urandom});
   endtask

   task automatic run_random(input int target);
      int first;
      first = items_sent;
      while (items_sent - first < target) begin
         if ($urandom_range(9) < 6) run_command();
         else run_noise();
      end
   endtask

   task automatic program_timing(input logic [CAP_W-1:0] base, input logic [CAP_W-1:0] span);
      write_reg(CSR_BASE, base);
      write_reg(CSR_SPAN, span);
   endtask

   initial begin
      logic [CAP_W-1:0] disk_size;
      mirror = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle = 19;
      recv_idle = 65;

      // No disk yet: the register window, the buffer edges and illegal accesses.
      push_beat(OP_READ, REG_CONTROL, '0);
      push_beat(OP_READ, REG_CAPACITY, '0);
      push_beat(OP_READ, BUF_OFFSET, '0);
      push_beat(OP_READ, BUF_LAST_BYTE, '0);
      push_beat(OP_READ, BUF_PAST_END, '0);
      push_beat(OP_READ, BUF_OFFSET - 1, '0);
      push_beat(OP_READ, ADDR_BITS'(4), '1);
      push_beat(OP_WRITE, BUF_OFFSET, '1);
      push_beat(OP_WRITE, BUF_LAST_WORD, 64'h0123_4567_89ab_cdef);
      push_beat(OP_READ, BUF_OFFSET + ADDR_BITS'(7), '0);
      push_beat(OP_READ, BUF_LAST_WORD, '0);
      push_beat(OP_WRITE, REG_CAPACITY, '1);
      push_beat(OP_WRITE, '1, '1);
      push_beat(OP_WRITE, REG_SECTOR, '1);
      push_beat(OP_WRITE, REG_COUNT, '0);
      // Start without a disk clears the status and arms nothing.
      push_beat(OP_WRITE, REG_CONTROL, CTRL_START | CTRL_IEN | CTRL_WRITE);
      push_beat(OP_TICK, '0, '0);
      push_beat(OP_WRITE, REG_CONTROL, CTRL_ALL & ~CTRL_START);
      push_beat(OP_READ, REG_CONTROL, '0);
      push_beat(OP_UNUSED, '1, '1);
      push_beat(OP_WRITE, REG_CONTROL, '0);
      push_beat(OP_WRITE, REG_SECTOR, '0);
      settle();

      // Power-up: the longest wait first, then a restart with no wait at all.
      write_reg(CSR_STARTUP, '1);
      write_reg(CSR_TOTAL, '1);
      push_beat(OP_TICK, '0, '0);
      push_beat(OP_TICK, '0, '0);
      settle();
      disk_size = ($urandom_range(1) != 0) ? '1 : CAP_W'($urandom_range(5000, 8));
      write_reg(CSR_STARTUP, '0);
      write_reg(CSR_TOTAL, disk_size);
      while (!mirror.control[CB_READY_BIT]) push_beat(OP_TICK, '0, '0);
      push_beat(OP_READ, REG_CAPACITY, '0);
      push_beat(OP_READ, REG_CONTROL, '0);
      settle();

      // Zero delays: a transfer at the end of the disk, then one past it.
      program_timing('0, '0);
      push_beat(OP_WRITE, REG_SECTOR, DATA_W'(disk_size) - 8);
      push_beat(OP_WRITE, REG_COUNT, DATA_W'(8));
      push_beat(OP_WRITE, REG_CONTROL, CTRL_START | CTRL_IEN);
      push_beat(OP_TICK, '0, '0);
      push_beat(OP_WRITE, REG_CONTROL, '0);
      push_beat(OP_WRITE, REG_SECTOR, DATA_W'(disk_size) - 1);
      push_beat(OP_WRITE, REG_COUNT, DATA_W'(2));
      push_beat(OP_WRITE, REG_CONTROL, CTRL_START | CTRL_WRITE);
      push_beat(OP_TICK, '0, '0);
      push_beat(OP_READ, REG_CONTROL, '0);
      settle();

      // Slow receiver, with one long hold-off that backs the block up.
      program_timing(CAP_W'($urandom_range(8)), CAP_W'($urandom_range(50, 1)));
      hold_left = 400;
      run_random(400);
      settle();
      program_timing('1, CAP_W'(7));
      run_random(60);
      settle();

      // Slow sender.
      send_idle = 65;
      recv_idle = 19;
      program_timing('0, '0);
      run_random(150);
      settle();
      program_timing(CAP_W'(2), '1);
      run_random(60);
      settle();
      write_reg(CSR_TOTAL, CAP_W'($urandom));
      program_timing(CAP_W'($urandom_range(10)), CAP_W'($urandom_range(40)));
      run_random(250);
      settle();

      // Both sides at full rate.
      send_idle = 0;
      recv_idle = 0;
      program_timing(CAP_W'($urandom_range(10)), CAP_W'($urandom_range(40)));
      run_random(350);
      settle();

      if (mirror.mismatches == 0 && mirror.due_responses.size() == 0) begin
         $display("[sector_disk_controller_core] OK");
      end else begin
         $display("[sector_disk_controller_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sdc_pkg.sv
hw/rtl/sdc_ram.sv
hw/rtl/sdc_divider.sv
hw/rtl/sdc_datapath.sv
hw/rtl/sdc_ctrl.sv
hw/rtl/sector_disk_controller_core.sv
hw/rtl/sdc_checker.sv
tb/testbench.sv
